// File: rtl/core/ebre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebre_pkg: shared types and constants for the battery runtime estimator
// Configuration register indexes and reset values, default parameter values,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ebre_pkg;

  localparam int POWER_WIDTH_DEF   = 32;
  localparam int EMA_FRAC_BITS_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FIELD_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHIFT = 2'd2;

  localparam logic        ENABLE_RST      = 1'b1;
  localparam logic [31:0] MAX_POWER_RST   = 32'd300000000;
  localparam logic [2:0]  ALPHA_SHIFT_RST = 3'd2;

  // Seconds per hour, and the width that holds it
  localparam int SEC_PER_HOUR   = 3600;
  localparam int SEC_PER_HOUR_W = 12;

  typedef struct packed {
    logic load_in;       // capture the request fields
    logic mark_accept;   // power reading passed the checks
    logic seed;          // first accepted reading seeds the average
    logic ema_diff;      // form |p - avg| and its direction
    logic ema_step;      // shift the difference by alpha
    logic ema_apply;     // move the average
    logic div_load;      // start the time-to-empty division
    logic div_step;      // one restoring division step
    logic out_load;      // load the output register
    logic out_est_valid; // estimate is valid for this result
  } ebre_cmd_t;

  typedef struct packed {
    logic enable;
    logic discharging;
    logic power_ok;
    logic seeded;
    logic est_ok;
    logic div_last;
    logic out_free;
  } ebre_sts_t;

endpackage

// File: rtl/core/ema_battery_runtime_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ema_battery_runtime_estimator: smoothed power and time-to-empty estimate
// Averages accepted power readings and divides remaining energy by the
// average to give seconds until the battery is empty.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  in_      request    in_valid/in_stall  discharging, energy/power present,
//                                         power_uw, energy_uwh
//  out_     result     out_valid/out_stall estimate_valid, seconds_left,
//                                         sample_accepted, average_power_uw
//  cfg_     write      cfg_we             cfg_index, cfg_wdata
//
//  One request at a time. With a valid estimate a request passes through
//  the check, the average update when the reading moves the average, the
//  division and the output register; the restoring divider retires one
//  quotient bit per cycle. A disabled block drops the request without a
//  result.
//  Reset is synchronous and active low; it restores the register defaults
//  and clears the average. A stalled result waits in the output register
//  while the next request is taken and worked on.
//
module ema_battery_runtime_estimator import ebre_pkg::*; #(
  parameter int POWER_WIDTH   = POWER_WIDTH_DEF,
  parameter int EMA_FRAC_BITS = EMA_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_discharging,
  input  logic                  in_energy_present,
  input  logic                  in_power_present,
  input  logic [FIELD_W-1:0]    in_power_uw,
  input  logic [FIELD_W-1:0]    in_energy_uwh,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_estimate_valid,
  output logic [FIELD_W-1:0]    out_seconds_left,
  output logic                  out_sample_accepted,
  output logic [FIELD_W-1:0]    out_average_power_uw
);

  ebre_cmd_t cmd;
  ebre_sts_t sts;

  // Sequencer: owns the request handshake and steps the datapath
  ebre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: config, average, divider and the result register
  ebre_dp #(
    .POWER_WIDTH   (POWER_WIDTH),
    .EMA_FRAC_BITS (EMA_FRAC_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_discharging       (in_discharging),
    .in_energy_present    (in_energy_present),
    .in_power_present     (in_power_present),
    .in_power_uw          (in_power_uw),
    .in_energy_uwh        (in_energy_uwh),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_estimate_valid   (out_estimate_valid),
    .out_seconds_left     (out_seconds_left),
    .out_sample_accepted  (out_sample_accepted),
    .out_average_power_uw (out_average_power_uw),
    .cmd                  (cmd),
    .sts                  (sts)
  );

  // A taken request keeps the input side busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // An invalid estimate reports zero seconds
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_estimate_valid |-> out_seconds_left == '0)
    else $error("seconds_left nonzero without a valid estimate");

  // Once a reading is accepted the average is at least one microwatt
  a_accept_nonzero_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sample_accepted || out_estimate_valid) |->
      out_average_power_uw != '0)
    else $error("zero average after an accepted reading");

  // No new result is loaded while a stalled one is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid || !out_stall)
    else $error("result overwritten while stalled");

endmodule

// File: rtl/core/ebre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebre_ctrl: sequencer for the battery runtime estimator
// Walks one request through check, average update, division and output.
// ----------------------------------------------------------------------------
module ebre_ctrl import ebre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ebre_sts_t sts,
  output ebre_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_CHECK     = 3'd1;
  localparam logic [2:0] ST_EMA_DIFF  = 3'd2;
  localparam logic [2:0] ST_EMA_STEP  = 3'd3;
  localparam logic [2:0] ST_EMA_APPLY = 3'd4;
  localparam logic [2:0] ST_EST       = 3'd5;
  localparam logic [2:0] ST_DIV_RUN   = 3'd6;
  localparam logic [2:0] ST_FIN       = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       est_valid_r, est_valid_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    est_valid_nxt = est_valid_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        est_valid_nxt = 1'b0;
        if (!sts.enable) begin
          state_nxt = ST_IDLE;          // drop the request
        end else if (!sts.discharging) begin
          state_nxt = ST_FIN;
        end else if (sts.power_ok) begin
          cmd.mark_accept = 1'b1;
          if (!sts.seeded) begin
            cmd.seed  = 1'b1;
            state_nxt = ST_EST;
          end else begin
            state_nxt = ST_EMA_DIFF;
          end
        end else begin
          state_nxt = ST_EST;
        end
      end
      ST_EMA_DIFF: begin
        cmd.ema_diff = 1'b1;
        state_nxt    = ST_EMA_STEP;
      end
      ST_EMA_STEP: begin
        cmd.ema_step = 1'b1;
        state_nxt    = ST_EMA_APPLY;
      end
      ST_EMA_APPLY: begin
        cmd.ema_apply = 1'b1;
        state_nxt     = ST_EST;
      end
      ST_EST: begin
        if (sts.est_ok) begin
          cmd.div_load = 1'b1;
          state_nxt    = ST_DIV_RUN;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          est_valid_nxt = 1'b1;
          state_nxt     = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.out_est_valid = est_valid_r;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      est_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      est_valid_r <= est_valid_nxt;
    end
  end

endmodule

// File: rtl/core/ebre_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebre_dp: datapath of the battery runtime estimator
// Configuration registers, power average, restoring divider, output register.
// ----------------------------------------------------------------------------
module ebre_dp import ebre_pkg::*; #(
  parameter int POWER_WIDTH   = POWER_WIDTH_DEF,
  parameter int EMA_FRAC_BITS = EMA_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_discharging,
  input  logic                  in_energy_present,
  input  logic                  in_power_present,
  input  logic [FIELD_W-1:0]    in_power_uw,
  input  logic [FIELD_W-1:0]    in_energy_uwh,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_estimate_valid,
  output logic [FIELD_W-1:0]    out_seconds_left,
  output logic                  out_sample_accepted,
  output logic [FIELD_W-1:0]    out_average_power_uw,
  input  ebre_cmd_t             cmd,
  output ebre_sts_t             sts
);

  localparam int AVG_W = POWER_WIDTH + EMA_FRAC_BITS;
  localparam int NUM_W = FIELD_W + SEC_PER_HOUR_W + EMA_FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  // Configuration
  logic                  enable_r;
  logic [FIELD_W-1:0]    max_power_r;
  logic [2:0]            shift_r;

  // Captured request
  logic                  disch_r;
  logic                  energy_ok_r;
  logic                  power_ok_r;
  logic [POWER_WIDTH-1:0] power_r;
  logic [FIELD_W-1:0]    energy_r;

  // Average state
  logic [AVG_W-1:0]      avg_r;
  logic                  seeded_r;
  logic                  accepted_r;
  logic [AVG_W-1:0]      diff_r;
  logic                  up_r;
  logic [AVG_W-1:0]      step_r;

  // Divider
  logic [NUM_W-1:0]      quo_r;
  logic [AVG_W-1:0]      rem_r;
  logic [CNT_W-1:0]      cnt_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_est_r;
  logic [FIELD_W-1:0]    out_sec_r;
  logic                  out_acc_r;
  logic [FIELD_W-1:0]    out_avg_r;

  logic [AVG_W-1:0]      p_fx;
  logic [AVG_W:0]        round_v;
  logic [AVG_W:0]        ceil_sum;
  logic [AVG_W:0]        trial;
  logic                  trial_ge;
  logic [NUM_W-1:0]      num_v;
  logic [63:0]           avg_int;
  logic [FIELD_W-1:0]    avg_sat;
  logic [FIELD_W-1:0]    quo_sat;

  assign p_fx     = AVG_W'(power_r) << EMA_FRAC_BITS;
  assign round_v  = ((AVG_W+1)'(1) << shift_r) - (AVG_W+1)'(1);
  assign ceil_sum = {1'b0, diff_r} + round_v;
  assign trial    = {rem_r, quo_r[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, avg_r});
  assign num_v    = (NUM_W'(energy_r) * NUM_W'(SEC_PER_HOUR)) << EMA_FRAC_BITS;
  assign avg_int  = 64'(avg_r >> EMA_FRAC_BITS);
  assign avg_sat  = (|avg_int[63:FIELD_W]) ? '1 : avg_int[FIELD_W-1:0];
  assign quo_sat  = (|quo_r[NUM_W-1:FIELD_W]) ? '1 : quo_r[FIELD_W-1:0];

  assign sts.enable      = enable_r;
  assign sts.discharging = disch_r;
  assign sts.power_ok    = power_ok_r && (|power_r) &&
                           (64'(power_r) <= 64'(max_power_r));
  assign sts.seeded      = seeded_r;
  assign sts.est_ok      = energy_ok_r && seeded_r && (|avg_r);
  assign sts.div_last    = (cnt_r == CNT_W'(NUM_W - 1));
  assign sts.out_free    = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= ENABLE_RST;
      max_power_r <= MAX_POWER_RST;
      shift_r     <= ALPHA_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:      enable_r    <= cfg_wdata[0];
        CFG_MAX_POWER:   max_power_r <= cfg_wdata;
        CFG_ALPHA_SHIFT: shift_r     <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      disch_r     <= in_discharging;
      energy_ok_r <= in_energy_present;
      power_ok_r  <= in_power_present;
      power_r     <= POWER_WIDTH'(in_power_uw);
      energy_r    <= in_energy_uwh;
    end
    if (cmd.load_in) begin
      accepted_r <= 1'b0;
    end else if (cmd.mark_accept) begin
      accepted_r <= 1'b1;
    end
  end

  // Average: seed, or move by the shifted difference (floor when rising, ceiling when falling)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r    <= '0;
      seeded_r <= 1'b0;
    end else if (cmd.seed) begin
      avg_r    <= p_fx;
      seeded_r <= 1'b1;
    end else if (cmd.ema_apply) begin
      avg_r <= up_r ? avg_r + step_r : avg_r - step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ema_diff) begin
      up_r   <= (p_fx >= avg_r);
      diff_r <= (p_fx >= avg_r) ? p_fx - avg_r : avg_r - p_fx;
    end
    if (cmd.ema_step) begin
      step_r <= up_r ? diff_r >> shift_r : AVG_W'(ceil_sum >> shift_r);
    end
  end

  // Restoring divider: numerator shifts out of quo_r as quotient bits shift in
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r <= num_v;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[NUM_W-2:0], trial_ge};
      rem_r <= trial_ge ? AVG_W'(trial - {1'b0, avg_r}) : trial[AVG_W-1:0];
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_est_r <= cmd.out_est_valid;
      out_sec_r <= cmd.out_est_valid ? quo_sat : '0;
      out_acc_r <= accepted_r;
      out_avg_r <= avg_sat;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_estimate_valid   = out_est_r;
  assign out_seconds_left     = out_sec_r;
  assign out_sample_accepted  = out_acc_r;
  assign out_average_power_uw = out_avg_r;

endmodule
